@@ hdl/fcpt_pkg.sv @@
// Shared constants, types and codes for the fern code posterior table.
package fcpt_pkg;

  localparam int COMPARISONS = 13;
  localparam int COUNT_BITS  = 16;

  localparam int CODE_BITS   = COMPARISONS;
  localparam int TABLE_DEPTH = 1 << COMPARISONS;
  localparam int FRAC_BITS   = 16;
  localparam int POST_BITS   = FRAC_BITS + 1;
  localparam int WORD_BITS   = 2 * COUNT_BITS;
  localparam int STEP_BITS   = $clog2(POST_BITS + 1);

  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COUNT_BITS:0]   total_t;
  typedef logic [POST_BITS-1:0]  post_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [1:0]            cmd_t;
  typedef logic [STEP_BITS-1:0]  step_t;

  localparam cmd_t CMD_QUERY     = 2'd0;
  localparam cmd_t CMD_TRAIN_POS = 2'd1;
  localparam cmd_t CMD_TRAIN_NEG = 2'd2;

  localparam count_t COUNT_MAX = '1;

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

@@ hdl/fcpt_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module fcpt_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 8192,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fcpt_div.sv @@
// Restoring divider producing pos * 2^16 / (pos + neg), one quotient bit a cycle.
module fcpt_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  fcpt_pkg::count_t dividend,
  input  fcpt_pkg::total_t divisor,
  output logic            finish,
  output fcpt_pkg::post_t quot
);
  import fcpt_pkg::*;

  logic   running;
  step_t  step;
  total_t rem;
  total_t dvs;
  logic   in_bit;

  logic [COUNT_BITS+1:0] trial;
  logic                  fits;

  always_comb begin
    trial = {rem, in_bit};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      step    <= '0;
    end else begin
      finish <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step_t'(step + 1'b1);
        if (step == step_t'(POST_BITS - 1)) begin
          running <= 1'b0;
          finish  <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient < 2^17, so the top of the dividend starts below the divisor
  always_ff @(posedge clk) begin
    if (go) begin
      rem    <= total_t'(dividend >> 1);
      in_bit <= dividend[0];
      dvs    <= divisor;
    end else if (running) begin
      in_bit <= 1'b0;
      rem    <= fits ? total_t'(trial - {1'b0, dvs}) : total_t'(trial);
      quot   <= {quot[POST_BITS-2:0], fits};
    end
  end

endmodule

@@ hdl/fern_code_posterior_table_unit.sv @@
// Top level: comparison code builder, count table update and posterior output.
// Sequence: a group's last pair starts a table read, then the divider, then a done beat.
// Throughput: non-final pairs are taken one per cycle while busy is low; a final pair
//   holds busy through a table read and a 17-step divider before the next beat.
// Reset: synchronous rst; afterwards busy stays high while the whole count table
//   is swept to zero, one entry a cycle. The receiver cannot stall.
module fern_code_posterior_table_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fcpt_pkg::cmd_t   cmd,
  input  logic [7:0]       pixel_first,
  input  logic [7:0]       pixel_second,
  input  logic             last_pair,
  output logic             done,
  output fcpt_pkg::code_t  fern_code,
  output fcpt_pkg::post_t  posterior,
  output logic             seen
);
  import fcpt_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_DIV    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  code_t code_shift;
  code_t code_next;
  code_t code_q;
  cmd_t  cmd_q;
  code_t clr_addr;
  logic  seen_q;

  // table word: positive count high, negative count low
  logic   ram_we;
  code_t  ram_waddr;
  word_t  ram_wdata;
  word_t  ram_rdata;

  count_t pos_upd;
  count_t neg_upd;
  total_t total;

  logic   div_go;
  logic   div_finish;
  post_t  div_quot;

  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // running code: shift in one comparison bit, keep the low COMPARISONS bits
  assign code_next = code_t'({code_shift, (pixel_first < pixel_second)});

  fcpt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (code_next),
    .rdata (ram_rdata)
  );

  // read-modify-write of the entry looked up in the previous cycle
  always_comb begin
    pos_upd = ram_rdata[WORD_BITS-1:COUNT_BITS];
    neg_upd = ram_rdata[COUNT_BITS-1:0];
    case (cmd_q)
      CMD_TRAIN_POS: pos_upd = sat_inc(ram_rdata[WORD_BITS-1:COUNT_BITS]);
      CMD_TRAIN_NEG: neg_upd = sat_inc(ram_rdata[COUNT_BITS-1:0]);
      default: ;
    endcase
    total = total_t'(pos_upd) + total_t'(neg_upd);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = code_q;
    ram_wdata = {pos_upd, neg_upd};
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == ST_LOOKUP) begin
      ram_we = (cmd_q == CMD_TRAIN_POS) || (cmd_q == CMD_TRAIN_NEG);
    end
  end

  assign div_go = (state == ST_LOOKUP);

  fcpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (pos_upd),
    .divisor  (total),
    .finish   (div_finish),
    .quot     (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:   if (accept && last_pair) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_DIV;
      ST_DIV:    if (div_finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      code_shift <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DIV) && div_finish;
      if (state == ST_CLEAR) begin
        clr_addr <= code_t'(clr_addr + 1'b1);
      end
      if (accept) begin
        code_shift <= last_pair ? '0 : code_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && last_pair) begin
      code_q <= code_next;
      cmd_q  <= cmd;
    end
    if (state == ST_LOOKUP) begin
      seen_q <= (total != '0);
    end
    if ((state == ST_DIV) && div_finish) begin
      fern_code <= code_q;
      seen      <= seen_q;
      posterior <= seen_q ? div_quot : '0;
    end
  end

endmodule
